/* rtl/sorted_priority_queue_with_drop_assert.svh */
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_WITH_DROP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_WITH_DROP_ASSERT_SVH

`ifndef SYNTHESIS
// property checked on clk, off while arst_n is low
`define SPQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("spq assertion failed");
// same-cycle implication
`define SPQ_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spq implication failed");
// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spq next-cycle implication failed");
`else
`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_IMPLY(lbl, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/spq_pkg.sv */
// types, codes and constants of the sorted priority queue
package spq_pkg;

	localparam int SPQ_DEPTH = 64;
	localparam int LIMIT_W   = 7;
	localparam int OCC_W     = 7;
	localparam int CNT_W     = 32;

	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] packet_id;
		logic [7:0]  priority_req;
		logic [31:0] size_word;
		logic [7:0]  source_node;
		logic [7:0]  dest_node;
		logic [31:0] arrival_word;
	} spq_in_t;

	typedef struct packed {
		logic             accepted;
		logic             head_valid;
		logic [15:0]      out_id;
		logic [7:0]       out_priority;
		logic [31:0]      out_size;
		logic [7:0]       out_source;
		logic [7:0]       out_dest;
		logic [31:0]      out_arrival;
		logic [OCC_W-1:0] occupancy;
		logic [CNT_W-1:0] enqueued_total;
		logic [CNT_W-1:0] dequeued_total;
		logic [CNT_W-1:0] dropped_total;
	} spq_out_t;

	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] id;
		logic [31:0] size;
		logic [7:0]  src;
		logic [7:0]  dst;
		logic [31:0] arrival;
	} spq_rec_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic     enq;
		logic     deq;
		spq_rec_t new_rec;
	} spq_cell_ctl_t;

endpackage

/* rtl/spq_cell.sv */
// one slot of the sorted row: keeps, takes the new record, or shifts
module spq_cell import spq_pkg::*; (
	input  logic          clk,
	input  spq_cell_ctl_t ctl,
	input  logic          occ,
	input  logic          prev_after,
	input  spq_rec_t      prev_rec,
	input  spq_rec_t      next_rec,
	output spq_rec_t      rec,
	output logic          after
);

	spq_rec_t rec_q;

	assign rec = rec_q;
	// new record lands behind every held record of equal or smaller key
	assign after = occ && (rec_q.prio <= ctl.new_rec.prio);

	always_ff @(posedge clk) begin
		priority if (ctl.enq) begin
			if (!after) begin
				rec_q <= prev_after ? ctl.new_rec : prev_rec;
			end
		end else if (ctl.deq) begin
			rec_q <= next_rec;
		end else begin
			rec_q <= rec_q;
		end
	end

endmodule

/* rtl/sorted_priority_queue_with_drop.sv */
// top level of the bounded sorted priority queue with drop counting
//
//  channel | signals                     | beat
//  in      | in_valid in_ready in_data   | one opcode with a packet record
//  out     | out_valid out_ready out_data | one result per input beat
//  cfg     | cfg_we cfg_wdata            | capacity limit, no handshake
//
// every beat is applied to the whole cell row at once: the row shifts or inserts in parallel
// the result waits in an output register; input is taken while it is empty
// or being drained, so a beat per cycle flows when out_ready stays high
// reset clears the count, the totals and the limit; cell contents stay
// undefined and are never shown before being written, so there is no clearing pass
`include "sorted_priority_queue_with_drop_assert.svh"

module sorted_priority_queue_with_drop import spq_pkg::*; #(
	parameter int DEPTH = SPQ_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  spq_in_t            in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output spq_out_t           out_data,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

	logic [CW-1:0]      count_q, count_d;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   enq_tot_q, deq_tot_q, drop_tot_q;
	logic [CNT_W-1:0]   enq_tot_d, deq_tot_d, drop_tot_d;
	logic               out_valid_q;
	spq_out_t           out_q, res_d;

	logic               fire, is_enq, is_deq, is_peek, full, has_head;
	logic               do_store, do_drop, do_deq;
	spq_cell_ctl_t      ctl;
	spq_rec_t           recs [DEPTH];
	logic [DEPTH-1:0]   after;

	assign in_ready  = !out_valid_q || out_ready;
	assign fire      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign is_enq   = in_data.opcode == OP_ENQ;
	assign is_deq   = in_data.opcode == OP_DEQ;
	assign is_peek  = in_data.opcode == OP_PEEK;
	assign has_head = count_q != '0;
	assign full     = (count_q == CW'(DEPTH))
		|| ((limit_q != '0) && (CMPW'(count_q) >= CMPW'(limit_q)));

	assign do_store = fire && is_enq && !full;
	assign do_drop  = fire && is_enq && full;
	assign do_deq   = fire && is_deq && has_head;

	always_comb begin
		ctl.enq             = do_store;
		ctl.deq             = do_deq;
		ctl.new_rec.prio    = in_data.priority_req;
		ctl.new_rec.id      = in_data.packet_id;
		ctl.new_rec.size    = in_data.size_word;
		ctl.new_rec.src     = in_data.source_node;
		ctl.new_rec.dst     = in_data.dest_node;
		ctl.new_rec.arrival = in_data.arrival_word;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic     occ;
		logic     prev_after;
		spq_rec_t prev_rec, next_rec;

		assign occ = CW'(i) < count_q;
		if (i == 0) begin : g_first
			assign prev_after = 1'b1;
			assign prev_rec   = ctl.new_rec;
		end else begin : g_mid
			assign prev_after = after[i-1];
			assign prev_rec   = recs[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_rec = recs[i];
		end else begin : g_inner
			assign next_rec = recs[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occ        (occ),
			.prev_after (prev_after),
			.prev_rec   (prev_rec),
			.next_rec   (next_rec),
			.rec        (recs[i]),
			.after      (after[i])
		);
	end

	always_comb begin
		count_d    = count_q;
		enq_tot_d  = enq_tot_q;
		deq_tot_d  = deq_tot_q;
		drop_tot_d = drop_tot_q;
		if (do_store) begin
			count_d   = count_q + 1'b1;
			enq_tot_d = enq_tot_q + 1'b1;
		end
		if (do_deq) begin
			count_d   = count_q - 1'b1;
			deq_tot_d = deq_tot_q + 1'b1;
		end
		if (do_drop) begin
			drop_tot_d = drop_tot_q + 1'b1;
		end
	end

	always_comb begin
		res_d                = '0;
		res_d.accepted       = do_store;
		if ((is_deq || is_peek) && has_head) begin
			res_d.head_valid   = 1'b1;
			res_d.out_id       = recs[0].id;
			res_d.out_priority = recs[0].prio;
			res_d.out_size     = recs[0].size;
			res_d.out_source   = recs[0].src;
			res_d.out_dest     = recs[0].dst;
			res_d.out_arrival  = recs[0].arrival;
		end
		res_d.occupancy      = OCC_W'(count_d);
		res_d.enqueued_total = enq_tot_d;
		res_d.dequeued_total = deq_tot_d;
		res_d.dropped_total  = drop_tot_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			limit_q     <= '0;
			enq_tot_q   <= '0;
			deq_tot_q   <= '0;
			drop_tot_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (fire) begin
				count_q     <= count_d;
				enq_tot_q   <= enq_tot_d;
				deq_tot_q   <= deq_tot_d;
				drop_tot_q  <= drop_tot_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res_d;
		end
	end

	`SPQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
	`SPQ_ASSERT_NEXT(a_store_grows, do_store, count_q == $past(count_q) + 1'b1)
	`SPQ_ASSERT_NEXT(a_drop_keeps, do_drop, $stable(count_q) && out_q.accepted == 1'b0)
	`SPQ_ASSERT_IMPLY(a_one_kind, out_valid_q, !(out_q.accepted && out_q.head_valid))
	`SPQ_ASSERT_IMPLY(a_head_sorted, count_q >= CW'(2), recs[0].prio <= recs[1].prio)

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench of the sorted priority queue with drop counting
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	spq_in_t            in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	spq_out_t           out_data;
	logic               cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;

	sorted_priority_queue_with_drop uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state
	spq_rec_t    held_recs [SPQ_DEPTH];
	int          held = 0;
	int unsigned limit_now = 0;
	logic [31:0] enq_cnt = '0;
	logic [31:0] deq_cnt = '0;
	logic [31:0] drop_cnt = '0;

	spq_in_t  pending_ops[$];
	spq_out_t awaited_results[$];
	int       fail_count = 0;
	logic     steady = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#(2_000_000);
		$display("testbench: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// applies one operation to the predicted queue and returns its result
	function automatic spq_out_t apply_queue_op(input spq_in_t req);
		spq_out_t    res;
		int          slot;
		int unsigned cap;
		res = '0;
		cap = (limit_now == 0 || limit_now > SPQ_DEPTH) ? SPQ_DEPTH : limit_now;
		case (req.opcode)
			OP_ENQ: begin
				if (held >= cap) begin
					drop_cnt = drop_cnt + 32'd1;
				end else begin
					slot = 0;
					// stable: equal keys go behind the ones already held
					while (slot < held && held_recs[slot].prio <= req.priority_req)
						slot++;
					for (int i = held; i > slot; i--)
						held_recs[i] = held_recs[i - 1];
					held_recs[slot].prio    = req.priority_req;
					held_recs[slot].id      = req.packet_id;
					held_recs[slot].size    = req.size_word;
					held_recs[slot].src     = req.source_node;
					held_recs[slot].dst     = req.dest_node;
					held_recs[slot].arrival = req.arrival_word;
					held++;
					enq_cnt = enq_cnt + 32'd1;
					res.accepted = 1'b1;
				end
			end
			OP_DEQ, OP_PEEK: begin
				if (held > 0) begin
					res.head_valid   = 1'b1;
					res.out_id       = held_recs[0].id;
					res.out_priority = held_recs[0].prio;
					res.out_size     = held_recs[0].size;
					res.out_source   = held_recs[0].src;
					res.out_dest     = held_recs[0].dst;
					res.out_arrival  = held_recs[0].arrival;
					if (req.opcode == OP_DEQ) begin
						for (int i = 0; i + 1 < held; i++)
							held_recs[i] = held_recs[i + 1];
						held--;
						deq_cnt = deq_cnt + 32'd1;
					end
				end
			end
			default: ;
		endcase
		res.occupancy      = OCC_W'(held);
		res.enqueued_total = enq_cnt;
		res.dequeued_total = deq_cnt;
		res.dropped_total  = drop_cnt;
		return res;
	endfunction

	// driver: one beat in flight, refilled from pending_ops
	always @(posedge clk) begin
		spq_in_t nxt_data;
		logic    nxt_valid;
		nxt_data = in_data;
		nxt_valid = in_valid;
		if (in_valid && in_ready) begin
			awaited_results.push_back(apply_queue_op(in_data));
			nxt_valid = 1'b0;
		end
		if (arst_n && !nxt_valid && pending_ops.size() > 0
				&& (steady || $urandom_range(99) >= 28)) begin
			nxt_data = pending_ops.pop_front();
			nxt_valid = 1'b1;
		end
		in_valid <= nxt_valid;
		in_data <= nxt_data;
	end

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 28);
	end

	// monitor: every result beat against the oldest prediction
	always @(posedge clk) begin
		spq_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with none awaited", 64'(out_data.occupancy), 64'd0);
			end else begin
				want = awaited_results.pop_front();
				if (out_data.accepted !== want.accepted)
					report_mismatch("accepted", 64'(out_data.accepted), 64'(want.accepted));
				if (out_data.head_valid !== want.head_valid)
					report_mismatch("head_valid", 64'(out_data.head_valid),
						64'(want.head_valid));
				if (out_data.out_id !== want.out_id)
					report_mismatch("out_id", 64'(out_data.out_id), 64'(want.out_id));
				if (out_data.out_priority !== want.out_priority)
					report_mismatch("out_priority", 64'(out_data.out_priority),
						64'(want.out_priority));
				if (out_data.out_size !== want.out_size)
					report_mismatch("out_size", 64'(out_data.out_size), 64'(want.out_size));
				if (out_data.out_source !== want.out_source)
					report_mismatch("out_source", 64'(out_data.out_source),
						64'(want.out_source));
				if (out_data.out_dest !== want.out_dest)
					report_mismatch("out_dest", 64'(out_data.out_dest), 64'(want.out_dest));
				if (out_data.out_arrival !== want.out_arrival)
					report_mismatch("out_arrival", 64'(out_data.out_arrival),
						64'(want.out_arrival));
				if (out_data.occupancy !== want.occupancy)
					report_mismatch("occupancy", 64'(out_data.occupancy),
						64'(want.occupancy));
				if (out_data.enqueued_total !== want.enqueued_total)
					report_mismatch("enqueued_total", 64'(out_data.enqueued_total),
						64'(want.enqueued_total));
				if (out_data.dequeued_total !== want.dequeued_total)
					report_mismatch("dequeued_total", 64'(out_data.dequeued_total),
						64'(want.dequeued_total));
				if (out_data.dropped_total !== want.dropped_total)
					report_mismatch("dropped_total", 64'(out_data.dropped_total),
						64'(want.dropped_total));
			end
		end
	end

	task automatic push_enq(input logic [7:0] prio, input logic [15:0] id,
			input logic [31:0] size, input logic [7:0] src, input logic [7:0] dst,
			input logic [31:0] arrival);
		spq_in_t item;
		item.opcode       = OP_ENQ;
		item.packet_id    = id;
		item.priority_req = prio;
		item.size_word    = size;
		item.source_node  = src;
		item.dest_node    = dst;
		item.arrival_word = arrival;
		pending_ops.push_back(item);
	endtask

	// non-enqueue ops carry random junk in the unused fields
	task automatic push_op(input logic [1:0] op);
		spq_in_t      item;
		logic [127:0] junk;
		junk = {$urandom, $urandom, $urandom, $urandom};
		item = junk[$bits(spq_in_t)-1:0];
		item.opcode = op;
		pending_ops.push_back(item);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_ops.size() != 0 || in_valid || awaited_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_limit(input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= LIMIT_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_now = value;
	endtask

	// bursts alternate between filling and draining so both ends get hit
	task automatic random_phase(input int count);
		spq_in_t      item;
		logic [127:0] junk;
		int           enq_pct;
		int           roll;
		for (int n = 0; n < count; n++) begin
			enq_pct = ((n / 34) % 2 == 0) ? 85 : 20;
			junk = {$urandom, $urandom, $urandom, $urandom};
			item = junk[$bits(spq_in_t)-1:0];
			roll = $urandom_range(99);
			if (roll < enq_pct)
				item.opcode = OP_ENQ;
			else if (roll < enq_pct + (100 - enq_pct) * 70 / 100)
				item.opcode = OP_DEQ;
			else if ($urandom_range(19) == 0)
				item.opcode = OP_UNUSED;
			else
				item.opcode = OP_PEEK;
			// narrow key ranges force ties so arrival order matters
			case ($urandom_range(3))
				0: item.priority_req = 8'($urandom_range(3));
				1: item.priority_req = 8'(252 + $urandom_range(3));
				default: item.priority_req = 8'($urandom_range(255));
			endcase
			if ($urandom_range(15) == 0)
				item.size_word = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
			if ($urandom_range(15) == 0)
				item.arrival_word = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
			pending_ops.push_back(item);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, extremes, ties and the unused opcode
		push_op(OP_DEQ);
		push_op(OP_PEEK);
		push_op(OP_UNUSED);
		push_enq(8'hff, 16'hffff, 32'hffff_ffff, 8'hff, 8'hff, 32'hffff_ffff);
		push_enq(8'h00, 16'h0000, 32'h0, 8'h00, 8'h00, 32'h0);
		push_enq(8'h80, 16'h1111, 32'h3f80_0000, 8'h01, 8'h02, 32'h4120_0000);
		push_enq(8'h80, 16'h2222, 32'h4000_0000, 8'h03, 8'h04, 32'h4140_0000);
		push_op(OP_PEEK);
		push_op(OP_UNUSED);
		repeat (4) push_op(OP_DEQ);
		push_op(OP_DEQ);
		push_op(OP_PEEK);
		wait_idle();

		// limit of one: second enqueue is dropped
		set_limit(1);
		push_enq(8'h10, 16'hbeef, 32'h1234_5678, 8'h0a, 8'h0b, 32'h8765_4321);
		push_enq(8'h01, 16'hcafe, 32'h5555_aaaa, 8'h0c, 8'h0d, 32'haaaa_5555);
		push_op(OP_PEEK);
		push_op(OP_DEQ);
		push_op(OP_DEQ);
		wait_idle();

		set_limit(SPQ_DEPTH);
		random_phase(170);
		wait_idle();
		set_limit(1);
		random_phase(170);
		wait_idle();
		set_limit(0);
		random_phase(170);
		wait_idle();
		for (int k = 0; k < 3; k++) begin
			set_limit($urandom_range(2, SPQ_DEPTH - 1));
			random_phase(170);
			wait_idle();
		end

		// no idling on either side for this stretch
		set_limit(0);
		steady = 1'b1;
		random_phase(170);
		wait_idle();
		steady = 1'b0;

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
